/* hw/rtl/ccsdf_pkg.sv */
// Package: widths, register map and pipeline types of the capped cylinder SDF block.
package ccsdf_pkg;
    localparam int INDEX_BITS = 20;
    localparam int FRAC_BITS  = 16;
    localparam int ADDR_BITS  = 5;
    localparam int SQ_STEPS   = 33;
    localparam int RAD_BITS   = 2 * SQ_STEPS;
    localparam int REM_BITS   = 36;
    localparam int ROOT_BITS  = 34;
    localparam int EXC_BITS   = 34;

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_BASE_Z   = 3'd2,
        REG_RADIUS   = 3'd3,
        REG_HEIGHT   = 3'd4,
        REG_VOXEL    = 3'd5,
        REG_BAND     = 3'd6,
        REG_NONE     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic                       far;
        logic signed [EXC_BITS-1:0] dxyd;
        logic signed [EXC_BITS-1:0] dzd;
    } t_side;

    typedef struct packed {
        logic                 valid;
        logic [RAD_BITS-1:0]  rad;
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
        t_side                side;
    } t_sq;
endpackage

/* hw/rtl/ccsdf_sqrt_cell.sv */
// One digit step of the bit-pair square root chain.
module ccsdf_sqrt_cell
    import ccsdf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sq  i_d,
    output t_sq  o_d
);
    logic [REM_BITS+1:0] rem_s;
    logic [REM_BITS+1:0] trial;
    t_sq                 n_d;
    t_sq                 r_d;

    always_comb begin
        rem_s      = {i_d.rem, i_d.rad[RAD_BITS-1 -: 2]};
        trial      = {2'b00, i_d.root, 2'b01};
        n_d        = i_d;
        n_d.rad    = {i_d.rad[RAD_BITS-3:0], 2'b00};
        if (rem_s >= trial) begin
            n_d.rem  = REM_BITS'(rem_s - trial);
            n_d.root = {i_d.root[ROOT_BITS-2:0], 1'b1};
        end else begin
            n_d.rem  = rem_s[REM_BITS-1:0];
            n_d.root = {i_d.root[ROOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else begin
            r_d.valid <= n_d.valid;
        end
        r_d.rad  <= n_d.rad;
        r_d.rem  <= n_d.rem;
        r_d.root <= n_d.root;
        r_d.side <= n_d.side;
    end

    assign o_d = r_d;
endmodule

/* hw/rtl/ccsdf_sqrt_chain.sv */
// Row of square root cells, one result bit per cell, rounded to nearest at the end.
module ccsdf_sqrt_chain
    import ccsdf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [RAD_BITS-1:0]  i_rad,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic [ROOT_BITS-1:0] o_root,
    output t_side                o_side
);
    t_sq link [SQ_STEPS+1];

    assign link[0].valid = i_valid;
    assign link[0].rad   = i_rad;
    assign link[0].rem   = '0;
    assign link[0].root  = '0;
    assign link[0].side  = i_side;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_cell
        ccsdf_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_d    (link[g]),
            .o_d    (link[g+1])
        );
    end

    assign o_valid = link[SQ_STEPS].valid;
    assign o_side  = link[SQ_STEPS].side;
    assign o_root  = link[SQ_STEPS].root
                   + ROOT_BITS'(link[SQ_STEPS].rem > {2'b00, link[SQ_STEPS].root});
endmodule

/* hw/rtl/capped_cylinder_sdf_voxel_top.sv */
// Top level: config registers, scaling, excess terms and two square root chains.
//
// Usage: pulse start with a voxel index on i_index_x/y/z; busy is always low,
// so one item is taken every cycle. Each item gives one result on o_distance
// and o_in_band, marked by o_valid for exactly one cycle, in input order.
// From the accepting edge to the strobe an item passes the scaling, offset
// and squaring stages, then a 33-cell square root chain for the radial
// length, an excess stage, a squaring stage, a second 33-cell chain for
// the outer length, and the final halving, clamp and band compare.
// Throughput is one item per cycle; every stage and cell is a register and
// hands its item on every cycle.
// Configuration goes through the APB port (register i at byte 4*i); write it
// only when no item is in flight.
// Reset (synchronous, active low) clears the pipeline valid bits and loads the
// register defaults. The receiver cannot stall: results must be taken when shown.
module capped_cylinder_sdf_voxel_top
    import ccsdf_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_BITS-1:0]         paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [INDEX_BITS-1:0] i_index_x,
    input  logic signed [INDEX_BITS-1:0] i_index_y,
    input  logic signed [INDEX_BITS-1:0] i_index_z,
    output logic                         o_valid,
    output logic signed [31:0]           o_distance,
    output logic                         o_in_band
);
    localparam int WB = INDEX_BITS + 32;

    logic signed [31:0] r_cx, r_cy, r_bz;
    logic [30:0]        r_rad, r_hgt, r_vs;
    logic [23:0]        r_band;
    logic [54:0]        r_lim;
    t_reg_idx           reg_idx;

    assign reg_idx = t_reg_idx'(paddr[ADDR_BITS-1:2]);
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_bz   <= '0;
            r_rad  <= 31'd655360;
            r_hgt  <= 31'd655360;
            r_vs   <= 31'd65536;
            r_band <= 24'd196608;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_CENTER_X: r_cx   <= pwdata;
                REG_CENTER_Y: r_cy   <= pwdata;
                REG_BASE_Z:   r_bz   <= pwdata;
                REG_RADIUS:   r_rad  <= pwdata[30:0];
                REG_HEIGHT:   r_hgt  <= pwdata[30:0];
                REG_VOXEL:    r_vs   <= pwdata[30:0];
                REG_BAND:     r_band <= pwdata[23:0];
                default: ;
            endcase
        end
        r_lim <= r_band * r_vs;
    end

    always_comb begin
        case (reg_idx)
            REG_CENTER_X: prdata = r_cx;
            REG_CENTER_Y: prdata = r_cy;
            REG_BASE_Z:   prdata = r_bz;
            REG_RADIUS:   prdata = {1'b0, r_rad};
            REG_HEIGHT:   prdata = {1'b0, r_hgt};
            REG_VOXEL:    prdata = {1'b0, r_vs};
            REG_BAND:     prdata = {8'd0, r_band};
            default:      prdata = '0;
        endcase
    end

    // scale to world
    logic                         r_v1;
    logic signed [INDEX_BITS-1:0] r_ix, r_iy, r_iz;
    logic                         r_v2;
    logic signed [WB-1:0]         r_wx, r_wy, r_wz;
    logic signed [31:0]           vs_s;

    assign vs_s = {1'b0, r_vs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
        end
        r_ix <= i_index_x;
        r_iy <= i_index_y;
        r_iz <= i_index_z;
        r_wx <= r_ix * vs_s;
        r_wy <= r_iy * vs_s;
        r_wz <= r_iz * vs_s;
    end

    // offsets and absolute values
    logic signed [WB:0]   dx, dy;
    logic [WB:0]          adx, ady;
    logic signed [WB+2:0] dz2;
    logic [WB+2:0]        adz;
    logic signed [WB+3:0] dzf;
    logic                 far_a;
    logic                 r_v3, r_far3;
    logic [31:0]          r_ax, r_ay;
    logic signed [EXC_BITS-1:0] r_dzd3;

    always_comb begin
        dx    = (WB+1)'(r_wx) - (WB+1)'(r_cx);
        dy    = (WB+1)'(r_wy) - (WB+1)'(r_cy);
        adx   = dx[WB] ? -dx : dx;
        ady   = dy[WB] ? -dy : dy;
        dz2   = ((WB+3)'(r_wz) <<< 1) - ((WB+3)'(r_bz) <<< 1) - (WB+3)'({1'b0, r_hgt});
        adz   = dz2[WB+2] ? -dz2 : dz2;
        dzf   = $signed({1'b0, adz}) - (WB+4)'({1'b0, r_hgt});
        far_a = (|adx[WB:32]) || (|ady[WB:32]) || (!dzf[WB+3] && (|dzf[WB+2:32]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_far3 <= far_a;
        r_ax   <= adx[31:0];
        r_ay   <= ady[31:0];
        r_dzd3 <= dzf[EXC_BITS-1:0];
    end

    // radial squares
    logic        r_v4;
    logic [63:0] r_ax2, r_ay2;
    t_side       r_side4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_ax2        <= r_ax * r_ax;
        r_ay2        <= r_ay * r_ay;
        r_side4.far  <= r_far3;
        r_side4.dxyd <= '0;
        r_side4.dzd  <= r_dzd3;
    end

    logic                 c1_v;
    logic [ROOT_BITS-1:0] c1_root;
    t_side                c1_side;

    ccsdf_sqrt_chain u_chain_xy (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_v4),
        .i_rad  (RAD_BITS'(r_ax2) + RAD_BITS'(r_ay2)),
        .i_side (r_side4),
        .o_valid(c1_v),
        .o_root (c1_root),
        .o_side (c1_side)
    );

    // radial excess
    logic signed [35:0]         dxy;
    logic signed [EXC_BITS-1:0] dxyd;
    logic                       r_v6;
    t_side                      r_side6;
    logic [31:0]                r_ex, r_ez;

    always_comb begin
        dxy  = $signed({2'b00, c1_root}) - $signed({5'd0, r_rad});
        dxyd = {dxy[EXC_BITS-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= c1_v;
        end
        r_side6.far  <= c1_side.far || (!dxy[35] && (|dxy[34:31]));
        r_side6.dxyd <= dxyd;
        r_side6.dzd  <= c1_side.dzd;
        r_ex         <= (dxyd > 0) ? dxyd[31:0] : '0;
        r_ez         <= (c1_side.dzd > 0) ? c1_side.dzd[31:0] : '0;
    end

    // outer squares
    logic        r_v7;
    logic [63:0] r_ex2, r_ez2;
    t_side       r_side7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else begin
            r_v7 <= r_v6;
        end
        r_ex2   <= r_ex * r_ex;
        r_ez2   <= r_ez * r_ez;
        r_side7 <= r_side6;
    end

    logic                 c2_v;
    logic [ROOT_BITS-1:0] c2_root;
    t_side                c2_side;

    ccsdf_sqrt_chain u_chain_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_v7),
        .i_rad  (RAD_BITS'(r_ex2) + RAD_BITS'(r_ez2)),
        .i_side (r_side7),
        .o_valid(c2_v),
        .o_root (c2_root),
        .o_side (c2_side)
    );

    // inner term, halving, clamp
    logic signed [EXC_BITS-1:0] mx, inn;
    logic signed [35:0]         sum1;
    logic signed [34:0]         half;
    logic signed [31:0]         sd_sat;
    logic                       r_v8;
    logic signed [31:0]         r_dist;

    always_comb begin
        mx   = (c2_side.dxyd > c2_side.dzd) ? c2_side.dxyd : c2_side.dzd;
        inn  = mx[EXC_BITS-1] ? mx : '0;
        sum1 = $signed({2'b00, c2_root}) + 36'(inn) + 36'sd1;
        half = sum1[35:1];
        if (c2_side.far) begin
            sd_sat = 32'sh7FFFFFFF;
        end else if (!half[34] && (|half[33:31])) begin
            sd_sat = 32'sh7FFFFFFF;
        end else if (half[34] && !(&half[33:31])) begin
            sd_sat = 32'sh80000000;
        end else begin
            sd_sat = half[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else begin
            r_v8 <= c2_v;
        end
        r_dist <= sd_sat;
    end

    // band check and output
    logic [32:0] mag;
    logic [63:0] mag_s;

    always_comb begin
        mag   = r_dist[31] ? -{1'b1, r_dist} : {1'b0, r_dist};
        mag_s = 64'(mag) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v8;
        end
        o_distance <= r_dist;
        o_in_band  <= mag_s < 64'(r_lim);
    end
endmodule
